// File: design/rstat_pkg.sv
// ----------------------------------------------------------------------------
// rstat_pkg: running statistics shared types and constants
// Request and response payloads, sequencer states and multiply step codes.
// ----------------------------------------------------------------------------
package rstat_pkg;

    localparam int MUL_W        = 32;
    localparam int PROD_W       = 2 * MUL_W;

    localparam int COUNT_OUT_W  = 32;
    localparam int SAMPLE_OUT_W = 16;
    localparam int MEAN_OUT_W   = 24;
    localparam int VAR_OUT_W    = 38;

    typedef struct packed {
        logic                           action;
        logic signed [SAMPLE_OUT_W-1:0] sample;
    } t_req;

    typedef struct packed {
        logic        [COUNT_OUT_W-1:0]  sample_count;
        logic signed [SAMPLE_OUT_W-1:0] last_sample;
        logic signed [SAMPLE_OUT_W-1:0] minimum;
        logic signed [SAMPLE_OUT_W-1:0] maximum;
        logic signed [MEAN_OUT_W-1:0]   mean;
        logic        [VAR_OUT_W-1:0]    variance;
        logic                           saturated;
    } t_rsp;

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_MUL      = 6'b000010,
        ST_ACC      = 6'b000100,
        ST_DIV_VAR  = 6'b001000,
        ST_DIV_MEAN = 6'b010000,
        ST_OUT      = 6'b100000
    } t_state;

    typedef logic [2:0] t_step;

    localparam t_step STEP_SQUARE = 3'd0;
    localparam t_step STEP_CNT_LO = 3'd1;
    localparam t_step STEP_CNT_HI = 3'd2;
    localparam t_step STEP_SUM_LL = 3'd3;
    localparam t_step STEP_SUM_LH = 3'd4;
    localparam t_step STEP_SUM_HH = 3'd5;
    localparam t_step STEP_CNT_SQ = 3'd6;

endpackage

// File: design/rstat_mul.sv
// ----------------------------------------------------------------------------
// rstat_mul: shared unsigned multiplier
// One 32 x 32 unsigned multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module rstat_mul (
    input  logic                          i_clk,
    input  logic [rstat_pkg::MUL_W-1:0]   i_a,
    input  logic [rstat_pkg::MUL_W-1:0]   i_b,
    output logic [rstat_pkg::PROD_W-1:0]  o_prod
);

    logic [rstat_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= rstat_pkg::PROD_W'(i_a) * rstat_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: design/rstat_div.sv
// ----------------------------------------------------------------------------
// rstat_div: shared restoring divider
// Radix-2 unsigned division, one quotient bit per cycle. The upper dividend
// part must be below the divisor; the user, not the block, holds it stable while busy.
// ----------------------------------------------------------------------------
module rstat_div #(
    parameter int DIVISOR_W = 64,
    parameter int QUOT_W    = 38
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIVISOR_W-1:0] i_dividend_hi,
    input  logic [QUOT_W-1:0]    i_dividend_lo,
    input  logic [DIVISOR_W-1:0] i_divisor,
    output logic [QUOT_W-1:0]    o_quot,
    output logic [DIVISOR_W-1:0] o_rem,
    output logic                 o_done
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DIVISOR_W-1:0] r_rem;
    logic [QUOT_W-1:0]    r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIVISOR_W:0]   w_trial;

    assign w_trial = {r_rem, r_quo[QUOT_W-1]} - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QUOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend_hi;
            r_quo <= i_dividend_lo;
        end else if (r_busy) begin
            if (!w_trial[DIVISOR_W]) begin
                r_rem <= w_trial[DIVISOR_W-1:0];
                r_quo <= {r_quo[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DIVISOR_W-2:0], r_quo[QUOT_W-1]};
                r_quo <= {r_quo[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

// File: design/running_stats_integer_top.sv
// ----------------------------------------------------------------------------
// running_stats_integer_top: running count, min, max, mean and variance
// Keeps count, last, min, max, sum and sum of squares of signed samples and
// answers each request with the full statistics set.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------
//   in      | input     | i_in_valid / o_in_ready   | i_in_req  (t_req)
//   out     | output    | o_out_valid / i_out_ready | o_out_rsp (t_rsp)
//
// push: seven passes through the shared 32x32 multiplier, six when the push
// is refused because the counter is full, then two runs of the shared radix-2
// divider, variance first and then mean; clear goes straight to the response
// o_in_ready is high only in the idle state; one held response may wait
// synchronous active-low reset clears all statistics, no clearing pass
// ----------------------------------------------------------------------------
module running_stats_integer_top #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rstat_pkg::t_req i_in_req,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output rstat_pkg::t_rsp o_out_rsp
);

    localparam int SUM_W  = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int SQ_W   = 2 * SAMPLE_WIDTH + COUNT_WIDTH - 2;
    localparam int ACC_W  = 2 * SUM_W;
    localparam int DV_W   = 2 * COUNT_WIDTH;
    localparam int QUO_W  = 2 * SAMPLE_WIDTH - 2 + FRACTION_BITS;
    localparam int DD_W   = ACC_W + FRACTION_BITS;
    localparam int MEAN_W = SAMPLE_WIDTH + FRACTION_BITS;
    localparam int MW     = rstat_pkg::MUL_W;

    rstat_pkg::t_state r_state, n_state;
    rstat_pkg::t_step  r_step;

    logic                           r_out_valid;
    logic                           r_refused;
    logic        [COUNT_WIDTH-1:0]  r_count;
    logic signed [SAMPLE_WIDTH-1:0] r_last;
    logic signed [SAMPLE_WIDTH-1:0] r_min;
    logic signed [SAMPLE_WIDTH-1:0] r_max;
    logic signed [SUM_W-1:0]        r_sum;
    logic        [SQ_W-1:0]         r_sumsq;

    logic        [SAMPLE_WIDTH-1:0] r_xabs;
    logic        [SUM_W-1:0]        r_sum_mag;
    logic                           r_sum_neg;
    logic        [ACC_W-1:0]        r_acc;
    logic        [DV_W-1:0]         r_cnt_sq;
    logic        [QUO_W-1:0]        r_var;
    logic signed [MEAN_W-1:0]       r_mean;
    rstat_pkg::t_rsp                r_rsp;

    logic                           w_in_acc;
    logic                           w_out_load;
    logic signed [SAMPLE_WIDTH-1:0] w_x;
    logic                           w_full;
    logic        [MW-1:0]           w_op_a;
    logic        [MW-1:0]           w_op_b;
    logic        [2*MW-1:0]         w_sq_pad;
    logic        [2*MW-1:0]         w_sm_pad;
    logic        [rstat_pkg::PROD_W-1:0] w_prod;
    logic        [DD_W-1:0]         w_dd;
    logic                           w_div_start;
    logic        [DV_W-1:0]         w_divisor;
    logic        [QUO_W-1:0]        w_quot;
    logic        [DV_W-1:0]         w_rem;
    logic                           w_div_done;
    logic        [MEAN_W-1:0]       w_mean_mag;

    assign o_in_ready = (r_state == rstat_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == rstat_pkg::ST_OUT) && (!r_out_valid || i_out_ready);
    assign w_x        = signed'(i_in_req.sample[SAMPLE_WIDTH-1:0]);
    assign w_full     = &r_count;

    // multiplier operands
    assign w_sq_pad = (2*MW)'(r_sumsq);
    assign w_sm_pad = (2*MW)'(r_sum_mag);

    always_comb begin
        w_op_a = MW'(r_count);
        w_op_b = MW'(r_count);
        case (r_step)
            rstat_pkg::STEP_SQUARE: begin
                w_op_a = MW'(r_xabs);
                w_op_b = MW'(r_xabs);
            end
            rstat_pkg::STEP_CNT_LO: w_op_b = w_sq_pad[MW-1:0];
            rstat_pkg::STEP_CNT_HI: w_op_b = w_sq_pad[2*MW-1:MW];
            rstat_pkg::STEP_SUM_LL: begin
                w_op_a = w_sm_pad[MW-1:0];
                w_op_b = w_sm_pad[MW-1:0];
            end
            rstat_pkg::STEP_SUM_LH: begin
                w_op_a = w_sm_pad[MW-1:0];
                w_op_b = w_sm_pad[2*MW-1:MW];
            end
            rstat_pkg::STEP_SUM_HH: begin
                w_op_a = w_sm_pad[2*MW-1:MW];
                w_op_b = w_sm_pad[2*MW-1:MW];
            end
            default: ;
        endcase
    end

    rstat_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .o_prod (w_prod)
    );

    // divider operands: variance first, then mean
    assign w_div_start = ((r_state == rstat_pkg::ST_ACC) && (r_step == rstat_pkg::STEP_CNT_SQ))
                      || ((r_state == rstat_pkg::ST_DIV_VAR) && w_div_done);
    assign w_dd = (r_state == rstat_pkg::ST_DIV_VAR)
                ? (DD_W'(r_sum_mag) << FRACTION_BITS)
                : (DD_W'(r_acc) << FRACTION_BITS);
    assign w_divisor = (r_state == rstat_pkg::ST_DIV_MEAN) ? DV_W'(r_count) : r_cnt_sq;

    rstat_div #(
        .DIVISOR_W (DV_W),
        .QUOT_W    (QUO_W)
    ) u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_div_start),
        .i_dividend_hi (DV_W'(w_dd >> QUO_W)),
        .i_dividend_lo (w_dd[QUO_W-1:0]),
        .i_divisor     (w_divisor),
        .o_quot        (w_quot),
        .o_rem         (w_rem),
        .o_done        (w_div_done)
    );

    // negative sums round the magnitude up so the mean is floored
    assign w_mean_mag = MEAN_W'(w_quot) + MEAN_W'(r_sum_neg && (w_rem != '0));

    always_comb begin
        n_state = r_state;
        case (r_state)
            rstat_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in_req.action == rstat_pkg::ACT_CLEAR)
                            ? rstat_pkg::ST_OUT : rstat_pkg::ST_MUL;
                end
            end
            rstat_pkg::ST_MUL: n_state = rstat_pkg::ST_ACC;
            rstat_pkg::ST_ACC: begin
                n_state = (r_step == rstat_pkg::STEP_CNT_SQ)
                        ? rstat_pkg::ST_DIV_VAR : rstat_pkg::ST_MUL;
            end
            rstat_pkg::ST_DIV_VAR: begin
                if (w_div_done) begin
                    n_state = rstat_pkg::ST_DIV_MEAN;
                end
            end
            rstat_pkg::ST_DIV_MEAN: begin
                if (w_div_done) begin
                    n_state = rstat_pkg::ST_OUT;
                end
            end
            rstat_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = rstat_pkg::ST_IDLE;
                end
            end
            default: n_state = rstat_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rstat_pkg::ST_IDLE;
            r_step      <= rstat_pkg::STEP_SQUARE;
            r_out_valid <= 1'b0;
            r_refused   <= 1'b0;
            r_count     <= '0;
            r_last      <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                rstat_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_req.action == rstat_pkg::ACT_CLEAR) begin
                            r_refused <= 1'b0;
                            r_count   <= '0;
                            r_last    <= '0;
                            r_min     <= '0;
                            r_max     <= '0;
                            r_sum     <= '0;
                            r_sumsq   <= '0;
                        end else if (w_full) begin
                            r_refused <= 1'b1;
                            r_step    <= rstat_pkg::STEP_CNT_LO;
                        end else begin
                            r_refused <= 1'b0;
                            r_step    <= rstat_pkg::STEP_SQUARE;
                            r_count   <= r_count + COUNT_WIDTH'(1);
                            r_last    <= w_x;
                            r_sum     <= r_sum + SUM_W'(w_x);
                            if (r_count == '0) begin
                                r_min <= w_x;
                                r_max <= w_x;
                            end else begin
                                if (w_x < r_min) begin
                                    r_min <= w_x;
                                end
                                if (w_x > r_max) begin
                                    r_max <= w_x;
                                end
                            end
                        end
                    end
                end
                rstat_pkg::ST_ACC: begin
                    if (r_step == rstat_pkg::STEP_SQUARE) begin
                        r_sumsq <= r_sumsq + SQ_W'(w_prod);
                    end
                    if (r_step != rstat_pkg::STEP_CNT_SQ) begin
                        r_step <= r_step + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_neg <= r_sum[SUM_W-1];
        r_sum_mag <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        if (w_in_acc) begin
            r_xabs <= w_x[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-w_x) : SAMPLE_WIDTH'(w_x);
        end
        if (r_state == rstat_pkg::ST_ACC) begin
            case (r_step)
                rstat_pkg::STEP_CNT_LO: r_acc <= ACC_W'(w_prod);
                rstat_pkg::STEP_CNT_HI: r_acc <= r_acc + (ACC_W'(w_prod) << MW);
                rstat_pkg::STEP_SUM_LL: r_acc <= r_acc - ACC_W'(w_prod);
                rstat_pkg::STEP_SUM_LH: r_acc <= r_acc - (ACC_W'(w_prod) << (MW + 1));
                rstat_pkg::STEP_SUM_HH: r_acc <= r_acc - (ACC_W'(w_prod) << (2 * MW));
                rstat_pkg::STEP_CNT_SQ: r_cnt_sq <= DV_W'(w_prod);
                default: ;
            endcase
        end
        if ((r_state == rstat_pkg::ST_DIV_VAR) && w_div_done) begin
            r_var <= w_quot;
        end
        if ((r_state == rstat_pkg::ST_DIV_MEAN) && w_div_done) begin
            r_mean <= r_sum_neg ? signed'(MEAN_W'(-w_mean_mag)) : signed'(w_mean_mag);
        end
        if (w_out_load) begin
            r_rsp.sample_count <= rstat_pkg::COUNT_OUT_W'(r_count);
            r_rsp.last_sample  <= rstat_pkg::SAMPLE_OUT_W'(r_last);
            r_rsp.minimum      <= rstat_pkg::SAMPLE_OUT_W'(r_min);
            r_rsp.maximum      <= rstat_pkg::SAMPLE_OUT_W'(r_max);
            r_rsp.mean         <= (r_count == '0) ? '0 : rstat_pkg::MEAN_OUT_W'(r_mean);
            r_rsp.variance     <= (r_count == '0) ? '0 : rstat_pkg::VAR_OUT_W'(r_var);
            r_rsp.saturated    <= r_refused;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

`ifndef NO_ASSERTIONS
    a_clear_zeroes_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_req.action == rstat_pkg::ACT_CLEAR)) |=> (r_count == '0))
        else $error("count not cleared after clear request");

    a_push_counts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_req.action == rstat_pkg::ACT_PUSH) && !w_full)
        |=> (r_count == COUNT_WIDTH'($past(r_count) + 1'b1)))
        else $error("accepted push did not advance count");

    a_div_done_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == rstat_pkg::ST_DIV_VAR) ||
                        (r_state == rstat_pkg::ST_DIV_MEAN)))
        else $error("divider finished outside a division state");
`endif

endmodule
